// ===== rtl/pvp_pkg.sv =====
// ----------------------------------------------------------------------------
// pvp_pkg
// Shared types and constants of the PCM voice player.
// ----------------------------------------------------------------------------
package pvp_pkg;

  localparam int unsigned Voices = 8;
  localparam int unsigned VoiceW = 3;

  localparam logic [1:0] OP_PLAY    = 2'd0;
  localparam logic [1:0] OP_LOOP    = 2'd1;
  localparam logic [1:0] OP_STOP    = 2'd2;
  localparam logic [1:0] OP_SERVICE = 2'd3;

  localparam logic [1:0] NIBBLE_RATE = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  voice_mask;
    logic [2:0]  voice_sel;
    logic [31:0] start_addr;
    logic [23:0] length;
    logic [7:0]  rate_code;
    logic [15:0] volume;
    logic [15:0] pan;
    logic [15:0] mode_word;
    logic [7:0]  fifo_status_mask;
    logic [7:0]  sample_byte;
    logic [31:0] now_time;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         voice_used;
    logic               sample_valid;
    logic signed [15:0] sample;
    logic [31:0]        fetch_addr;
    logic [7:0]         rate_out;
    logic [7:0]         hw_flags;
    logic [15:0]        vol_out;
    logic [15:0]        pan_out;
    logic [7:0]         updated_mask;
    logic [7:0]         active_mask;
  } res_t;

  // one voice record held in the voice memory
  typedef struct packed {
    logic [31:0] age;
    logic [31:0] read_addr;
    logic [23:0] remaining;
    logic        phase;
    logic        nib_mode;
    logic        loop_en;
    logic [31:0] loop_addr;
    logic [23:0] loop_len;
  } voice_t;

endpackage

// ===== rtl/pvp_if.sv =====
// ----------------------------------------------------------------------------
// pvp_cmd_if / pvp_res_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface pvp_cmd_if;
  logic           valid;
  logic           ready;
  pvp_pkg::cmd_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pvp_res_if;
  logic           valid;
  logic           ready;
  pvp_pkg::res_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/pvp_voice_ram.sv =====
// ----------------------------------------------------------------------------
// pvp_voice_ram
// Voice record memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module pvp_voice_ram (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [2:0]           waddr_i,
  input  pvp_pkg::voice_t      wdata_i,
  input  logic [2:0]           raddr_i,
  output pvp_pkg::voice_t      rdata_o
);
  import pvp_pkg::*;

  voice_t mem [Voices];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/pcm_voice_player.sv =====
// ----------------------------------------------------------------------------
// pcm_voice_player
// Eight-voice PCM sample player with oldest-voice stealing.
// ----------------------------------------------------------------------------
// Steps: service reads its voice, the others scan; both then execute and output.
// Throughput: one item at a time; loop, stop and play walk all eight records
// through the single read port of the voice memory, one voice per cycle.
// Reset: control, the valid and per-voice bits (active, loop, written) clear at
// once; voice records carry a flag per voice that marks them as reset-valued.
module pcm_voice_player (
  input  logic         clk_i,
  input  logic         rst_ni,
  pvp_cmd_if.sink      cmd_i,
  pvp_res_if.source    res_o
);
  import pvp_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_EXEC = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]  state_q, state_d;
  cmd_t        cmd_q;
  logic [3:0]  cnt_q, cnt_d;
  logic [2:0]  pick_q, pick_d;
  logic        found_q, found_d, busy_q, busy_d;
  logic [31:0] best_q, best_d;
  logic [7:0]  written_q, written_d;
  logic [7:0]  active_q, active_d;
  logic [7:0]  loop_q, loop_d;
  res_t        res_q, res_d;
  logic        rvalid_q, rvalid_d;

  logic        we;
  logic [2:0]  waddr, raddr;
  voice_t      wdata, rdata, rec;
  logic [2:0]  scan_idx;

  pvp_voice_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cmd_i.ready = (state_q == ST_IDLE) && !rvalid_q;
  assign res_o.valid = rvalid_q;
  assign res_o.data  = res_q;

  // scan reads voice cnt, registered data in the next cycle is for cnt-1
  assign scan_idx = cnt_q[2:0] - 3'd1;
  assign raddr = (state_q == ST_IDLE) ? cmd_i.data.voice_sel :
                 (state_q == ST_SCAN) ? cnt_q[2:0] : pick_q;

  always_comb begin
    rec = rdata;
    if (!written_q[(state_q == ST_SCAN) ? scan_idx : pick_q]) begin
      rec = '0;
    end
    rec.loop_en = loop_q[(state_q == ST_SCAN) ? scan_idx : pick_q];
  end

  always_comb begin
    logic [23:0] rem;
    logic [7:0]  m;
    logic [3:0]  nib;
    logic [31:0] vs;
    state_d   = state_q;
    cnt_d     = cnt_q;
    pick_d    = pick_q;
    found_d   = found_q;
    busy_d    = busy_q;
    best_d    = best_q;
    written_d = written_q;
    active_d  = active_q;
    loop_d    = loop_q;
    res_d     = res_q;
    rvalid_d  = rvalid_q;
    we        = 1'b0;
    waddr     = pick_q;
    wdata     = rec;
    rem       = '0;
    nib       = '0;
    vs        = '0;
    m         = cmd_q.voice_mask;
    if (rvalid_q && res_o.ready) begin
      rvalid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid && cmd_i.ready) begin
          cnt_d   = '0;
          pick_d  = cmd_i.data.voice_sel;
          found_d = 1'b0;
          busy_d  = 1'b0;
          best_d  = '0;
          state_d = (cmd_i.data.opcode == OP_SERVICE) ? ST_RD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // age compare only matters for play; loop and stop use the bits
        if (cnt_q != 4'd0 && m[scan_idx] && !found_q) begin
          if (!active_q[scan_idx] && cmd_q.fifo_status_mask[scan_idx]) begin
            pick_d  = scan_idx;
            found_d = 1'b1;
          end else if (!busy_q || rec.age < best_q) begin
            best_d = rec.age;
            pick_d = scan_idx;
            busy_d = 1'b1;
          end
        end
        if (cnt_q == 4'd0) begin
          pick_d = '0;
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(Voices)) begin
          state_d = ST_EXEC;
        end
      end
      ST_RD: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        res_d = '0;
        case (cmd_q.opcode)
          OP_PLAY: begin
            we = 1'b1;
            wdata.age       = cmd_q.now_time;
            wdata.read_addr = cmd_q.start_addr;
            wdata.remaining = cmd_q.length;
            wdata.nib_mode  = (cmd_q.rate_code[1:0] == NIBBLE_RATE);
            wdata.phase     = 1'b0;
            wdata.loop_en   = 1'b0;
            wdata.loop_addr = cmd_q.start_addr;
            wdata.loop_len  = cmd_q.length;
            written_d[pick_q] = 1'b1;
            loop_d[pick_q]    = 1'b0;
            active_d[pick_q]  = (cmd_q.length != '0);
            vs = 32'(cmd_q.volume) * 32'd96;
            res_d.voice_used   = pick_q;
            res_d.rate_out     = cmd_q.rate_code;
            res_d.hw_flags     = cmd_q.mode_word[15:8];
            res_d.vol_out      = vs[22:7];
            res_d.pan_out      = cmd_q.pan;
            res_d.updated_mask = 8'(1) << pick_q;
            if (cmd_q.length != '0) begin
              res_d.fetch_addr = cmd_q.start_addr ^ 32'd1;
            end
          end
          OP_LOOP: begin
            loop_d = loop_q | m;
            res_d.vol_out      = cmd_q.volume;
            res_d.pan_out      = cmd_q.pan;
            res_d.updated_mask = m;
          end
          OP_STOP: begin
            loop_d = loop_q & ~m;
            if (cmd_q.mode_word == '0) begin
              active_d = active_q & ~m;
            end
          end
          default: begin
            res_d.voice_used = pick_q;
            rem = rec.remaining;
            if (!active_q[pick_q]) begin
              rem = '0;
            end
            if (rem != '0 && !cmd_q.fifo_status_mask[pick_q]) begin
              we = 1'b1;
              if (rec.nib_mode) begin
                nib = rec.phase ? cmd_q.sample_byte[3:0] : cmd_q.sample_byte[7:4];
                wdata.phase = !rec.phase;
                if (rec.phase) begin
                  wdata.read_addr = rec.read_addr + 32'd1;
                end
                res_d.sample = {~nib[3], nib[2:0], 12'd0};
              end else begin
                wdata.read_addr = rec.read_addr + 32'd1;
                res_d.sample = {~cmd_q.sample_byte[7], cmd_q.sample_byte[6:0], 8'd0};
              end
              res_d.sample_valid = 1'b1;
              rem = rem - 24'd1;
              if (rem == '0 && rec.loop_en) begin
                wdata.read_addr = rec.loop_addr;
                rem = rec.loop_len;
                wdata.phase = 1'b0;
              end
              wdata.remaining = rem;
              active_d[pick_q] = (rem != '0);
            end
            if (rem != '0) begin
              res_d.fetch_addr = wdata.read_addr ^ 32'd1;
            end
          end
        endcase
        state_d = ST_OUT;
      end
      ST_OUT: begin
        res_d.active_mask = active_q;
        rvalid_d = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      pick_q    <= '0;
      found_q   <= 1'b0;
      busy_q    <= 1'b0;
      best_q    <= '0;
      written_q <= '0;
      active_q  <= '0;
      loop_q    <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pick_q    <= pick_d;
      found_q   <= found_d;
      busy_q    <= busy_d;
      best_q    <= best_d;
      written_q <= written_d;
      active_q  <= active_d;
      loop_q    <= loop_d;
      rvalid_q  <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i.valid && cmd_i.ready) begin
      cmd_q <= cmd_i.data;
    end
  end

endmodule

// ===== rtl/pvp_checker.sv =====
// ----------------------------------------------------------------------------
// pvp_checker
// Port-level checks on the voice player, bound to the top level.
// ----------------------------------------------------------------------------
module pvp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          cmd_valid_i,
  input logic          cmd_ready_i,
  input logic          res_valid_i,
  input logic          res_ready_i,
  input pvp_pkg::res_t res_i
);
  import pvp_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_i))
    else $error("result changed while stalled");

  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("second item taken before result");

  a_smp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_i.sample_valid |-> res_i.sample == '0)
    else $error("sample without valid");

  a_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_i.fetch_addr != '0 && res_i.updated_mask == '0
      && res_i.sample_valid |-> res_i.active_mask[res_i.voice_used])
    else $error("fetch for idle voice");

endmodule

bind pcm_voice_player pvp_checker u_pvp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid_i (cmd_i.valid),
  .cmd_ready_i (cmd_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_i       (res_o.data)
);

// ===== tb/tb_pvp_pkg_note.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pvp_voice_state
// Voice record held by the testbench's own copy of the player.
// ----------------------------------------------------------------------------
package tb_pvp_voice_state;
  typedef struct {
    logic [31:0] age;
    logic [31:0] rd_addr;
    logic [23:0] left;
    logic        phase;
    logic        nib_mode;
    logic        loop_en;
    logic [31:0] lp_addr;
    logic [23:0] lp_len;
  } tb_voice_t;
endpackage

// ===== tb/tb_pcm_voice_player.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pcm_voice_player
// Drives play, loop, stop and service items into the voice player, predicts
// every result with an internal voice model and compares field by field.
// ----------------------------------------------------------------------------
module tb_pcm_voice_player;
  import pvp_pkg::*;
  import tb_pvp_voice_state::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  pvp_cmd_if cmd_ch();
  pvp_res_if res_ch();

  pcm_voice_player uut (.clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd_ch), .res_o(res_ch));

  cmd_t      pending_cmds[$];
  res_t      expected_res[$];
  tb_voice_t voices[8];
  int        errors = 0;
  bit        stim_done = 0;
  bit        calm = 0;
  bit        cmd_taken = 0;
  int        hold_off = 0;
  int        hold_start = 0;
  int        res_count = 0;
  int        calm_lo = 600, calm_hi = 900;

  function automatic logic [7:0] active_now();
    logic [7:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) if (voices[i].left != 0) m[i] = 1'b1;
    return m;
  endfunction

  // compute the result of one item and advance the voice copy
  function automatic res_t play_step(cmd_t c);
    res_t r;
    int   pick;
    bit   busy_seen;
    logic [31:0] best;
    logic [3:0]  nib;
    int   s;
    r = '0;
    pick = 0;
    busy_seen = 0;
    best = '0;
    case (c.opcode)
      OP_PLAY: begin
        for (int i = 0; i < 8; i++) begin
          if (!c.voice_mask[i]) continue;
          if (voices[i].left == 0 && c.fifo_status_mask[i]) begin
            pick = i;
            break;
          end
          if (!busy_seen || voices[i].age < best) begin
            best = voices[i].age;
            pick = i;
            busy_seen = 1;
          end
        end
        voices[pick].age = c.now_time;
        voices[pick].rd_addr = c.start_addr;
        voices[pick].left = c.length;
        voices[pick].nib_mode = (c.rate_code[1:0] == NIBBLE_RATE);
        voices[pick].phase = 0;
        voices[pick].loop_en = 0;
        voices[pick].lp_addr = c.start_addr;
        voices[pick].lp_len = c.length;
        r.voice_used = pick[2:0];
        r.rate_out = c.rate_code;
        r.hw_flags = c.mode_word[15:8];
        r.vol_out = 16'((32'(c.volume) * 96) / 128);
        r.pan_out = c.pan;
        r.updated_mask = 8'(1 << pick);
        if (c.length != 0) r.fetch_addr = c.start_addr ^ 32'd1;
      end
      OP_LOOP: begin
        for (int i = 0; i < 8; i++) if (c.voice_mask[i]) voices[i].loop_en = 1;
        r.vol_out = c.volume;
        r.pan_out = c.pan;
        r.updated_mask = c.voice_mask;
      end
      OP_STOP: begin
        for (int i = 0; i < 8; i++) if (c.voice_mask[i]) begin
          if (c.mode_word == 0) voices[i].left = 0;
          voices[i].loop_en = 0;
        end
      end
      default: begin
        s = int'(c.voice_sel);
        r.voice_used = c.voice_sel;
        if (voices[s].left != 0 && !c.fifo_status_mask[s]) begin
          if (voices[s].nib_mode) begin
            if (!voices[s].phase) begin
              nib = c.sample_byte[7:4];
              voices[s].phase = 1;
            end else begin
              nib = c.sample_byte[3:0];
              voices[s].phase = 0;
              voices[s].rd_addr += 1;
            end
            r.sample = {nib, 12'h000} ^ 16'h8000;
          end else begin
            voices[s].rd_addr += 1;
            r.sample = {c.sample_byte, 8'h00} ^ 16'h8000;
          end
          r.sample_valid = 1;
          voices[s].left -= 1;
          if (voices[s].left == 0 && voices[s].loop_en) begin
            voices[s].rd_addr = voices[s].lp_addr;
            voices[s].left = voices[s].lp_len;
            voices[s].phase = 0;
          end
        end
        if (voices[s].left != 0) r.fetch_addr = voices[s].rd_addr ^ 32'd1;
      end
    endcase
    r.active_mask = active_now();
    return r;
  endfunction

  function automatic cmd_t rand_cmd(logic [1:0] op);
    cmd_t c;
    c.opcode = op;
    c.voice_mask = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'(1 << $urandom_range(0, 7));
    if ($urandom_range(0, 5) == 0) c.voice_mask = 8'hFF;
    c.voice_sel = 3'($urandom_range(0, 7));
    c.start_addr = $urandom;
    c.length = $urandom_range(0, 9) == 0 ? 24'($urandom) : 24'($urandom_range(0, 12));
    c.rate_code = 8'($urandom);
    c.volume = 16'($urandom);
    c.pan = 16'($urandom);
    c.mode_word = $urandom_range(0, 1) ? 16'h0000 : 16'($urandom);
    c.fifo_status_mask = 8'($urandom);
    c.sample_byte = 8'($urandom);
    c.now_time = $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 3)) : 32'($urandom);
    return c;
  endfunction

  function automatic logic [1:0] pick_op();
    int k;
    k = $urandom_range(0, 99);
    if (k < 20) return OP_PLAY;
    if (k < 28) return OP_LOOP;
    if (k < 34) return OP_STOP;
    return OP_SERVICE;
  endfunction

  // note whether the item on offer was taken at this edge
  always @(posedge clk_i) begin
    cmd_taken <= rst_ni && cmd_ch.valid && cmd_ch.ready;
  end

  // driver: change inputs at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_taken) begin
      if (pending_cmds.size() != 0 && (calm || $urandom_range(0, 99) >= 38)) begin
        cmd_ch.data <= pending_cmds[0];
        expected_res.push_back(play_step(pending_cmds.pop_front()));
        cmd_ch.valid <= 1'b1;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // receiver readiness, with one long hold-off counted here
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res_ch.ready <= 1'b0;
    end else if (hold_start == 1) begin
      hold_start <= 2;
      hold_off <= 400;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= calm || ($urandom_range(0, 99) >= 38);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    res_t a, e;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      a = res_ch.data;
      res_count <= res_count + 1;
      if (res_count == 300 && hold_start == 0) hold_start <= 1;
      if (res_count == calm_lo) calm <= 1;
      if (res_count == calm_hi) calm <= 0;
      if (expected_res.size() == 0) begin
        $error("result with no expected item");
        errors++;
      end else begin
        e = expected_res.pop_front();
        if (a.voice_used !== e.voice_used) begin
          $error("voice_used exp %0d got %0d", e.voice_used, a.voice_used); errors++;
        end
        if (a.sample_valid !== e.sample_valid) begin
          $error("sample_valid exp %0d got %0d", e.sample_valid, a.sample_valid); errors++;
        end
        if (a.sample !== e.sample) begin
          $error("sample exp %0d got %0d", e.sample, a.sample); errors++;
        end
        if (a.fetch_addr !== e.fetch_addr) begin
          $error("fetch_addr exp %h got %h", e.fetch_addr, a.fetch_addr); errors++;
        end
        if (a.rate_out !== e.rate_out) begin
          $error("rate_out exp %h got %h", e.rate_out, a.rate_out); errors++;
        end
        if (a.hw_flags !== e.hw_flags) begin
          $error("hw_flags exp %h got %h", e.hw_flags, a.hw_flags); errors++;
        end
        if (a.vol_out !== e.vol_out) begin
          $error("vol_out exp %h got %h", e.vol_out, a.vol_out); errors++;
        end
        if (a.pan_out !== e.pan_out) begin
          $error("pan_out exp %h got %h", e.pan_out, a.pan_out); errors++;
        end
        if (a.updated_mask !== e.updated_mask) begin
          $error("updated_mask exp %h got %h", e.updated_mask, a.updated_mask); errors++;
        end
        if (a.active_mask !== e.active_mask) begin
          $error("active_mask exp %h got %h", e.active_mask, a.active_mask); errors++;
        end
      end
    end
  end

  initial begin
    cmd_t c;
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    res_ch.ready = 1'b0;
    for (int i = 0; i < 8; i++) voices[i] = '{default: '0};
    // directed: idle picks, empty mask, zero length, nibble and byte playback
    c = rand_cmd(OP_PLAY);
    c.voice_mask = 8'h00; c.length = 24'd3; c.rate_code = 8'h02; c.start_addr = 32'hFFFF_FFFF;
    c.volume = 16'hFFFF; c.mode_word = 16'hFFFF; c.now_time = 32'd5;
    pending_cmds.push_back(c);
    c = rand_cmd(OP_PLAY);
    c.voice_mask = 8'hFF; c.fifo_status_mask = 8'hFF; c.length = 24'd0; c.volume = 16'h0;
    pending_cmds.push_back(c);
    c = rand_cmd(OP_PLAY);
    c.voice_mask = 8'h02; c.fifo_status_mask = 8'h02; c.length = 24'hFF_FFFF;
    c.rate_code = 8'h01; c.now_time = 32'hFFFF_FFFF;
    pending_cmds.push_back(c);
    for (int k = 0; k < 4; k++) begin
      c = rand_cmd(OP_SERVICE);
      c.voice_sel = 3'd0; c.fifo_status_mask = 8'h00; c.sample_byte = k[0] ? 8'hFF : 8'h00;
      pending_cmds.push_back(c);
    end
    c = rand_cmd(OP_SERVICE);
    c.voice_sel = 3'd1; c.fifo_status_mask = 8'h02;
    pending_cmds.push_back(c);
    c = rand_cmd(OP_SERVICE);
    c.voice_sel = 3'd7; c.fifo_status_mask = 8'h00;
    pending_cmds.push_back(c);
    // every voice busy: steal the oldest
    c = rand_cmd(OP_PLAY);
    c.voice_mask = 8'hFF; c.fifo_status_mask = 8'h00; c.length = 24'd4;
    pending_cmds.push_back(c);
    c = rand_cmd(OP_LOOP);
    c.voice_mask = 8'hFF; c.volume = 16'hFFFF; c.pan = 16'h0;
    pending_cmds.push_back(c);
    for (int k = 0; k < 6; k++) begin
      c = rand_cmd(OP_SERVICE);
      c.voice_sel = 3'd0; c.fifo_status_mask = 8'h00;
      pending_cmds.push_back(c);
    end
    c = rand_cmd(OP_STOP);
    c.voice_mask = 8'hFF; c.mode_word = 16'h0100;
    pending_cmds.push_back(c);
    c = rand_cmd(OP_STOP);
    c.voice_mask = 8'hFF; c.mode_word = 16'h0000;
    pending_cmds.push_back(c);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // random: mostly servicing of voices that play, with loops and stops
    for (int n = 0; n < 1700; n++) pending_cmds.push_back(rand_cmd(pick_op()));
    wait (pending_cmds.size() == 0 && expected_res.size() == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
